[design/bffa_pkg.sv]
// Package for the first-fit sector allocator: beat structs, bitmap geometry
// constants and action codes. Depends on nothing.
`default_nettype none
package bffa_pkg;

  // Bitmap geometry
  localparam int BITMAP_SECTORS = 16;
  localparam int SECTOR_BYTES   = 16;
  localparam int STORE_BYTES    = 256;
  localparam int SCAN_PROD      = BITMAP_SECTORS * SECTOR_BYTES;
  localparam int SCAN_BYTES     = (SCAN_PROD > STORE_BYTES) ? STORE_BYTES : SCAN_PROD;

  // Memory organization: eight bitmap bytes per row, first byte in the top lane
  localparam int ROW_BYTES = 8;
  localparam int ROW_BITS  = ROW_BYTES * 8;
  localparam int ROWS      = STORE_BYTES / ROW_BYTES;
  localparam int ROW_AW    = $clog2(ROWS);
  localparam int LANE_W    = $clog2(ROW_BYTES);
  localparam int POS_W     = $clog2(ROW_BITS);
  localparam int LAST_ROW  = (SCAN_BYTES - 1) / ROW_BYTES;
  localparam int IDX_W     = ROW_AW + LANE_W + 1;
  localparam int SECTOR_W  = 11;

  // Action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] byte_addr;
    logic [7:0] byte_value;
  } in_t;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic                ok;
  } out_t;

endpackage
`default_nettype wire

[design/bitmap_first_free_allocator_top.sv]
// First-fit sector allocator over a 2048-bit free-sector bitmap.
// Depends on bffa_pkg for beat structs, geometry and action codes.
//
//   channel   ports                      handshake
//   input     start, busy, in_data       beat taken when start && !busy
//   result    out_strobe, out_data       one cycle per beat, no back-pressure
//
// The bitmap sits in a 32 x 64-bit synchronous RAM (one read, one write port).
// A byte write goes from accept to result through row read, merge and write back.
// An allocation reads one row per cycle with the check of the previous row
// overlapped, and ends at the first row that holds a free bit, or with a
// failed result after the last row when the scanned range is full.
// Reset clears 32 per-row valid flags at once; a row never written reads as zero,
// so no clearing pass is needed. busy is low again in the cycle of the result.
`default_nettype none
module bitmap_first_free_allocator_top (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  output logic             busy,
  input  bffa_pkg::in_t    in_data,
  output logic             out_strobe,
  output bffa_pkg::out_t   out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN
  } state_t;

  // Control and payload registers
  state_t                        state_r, state_nxt;
  logic [bffa_pkg::ROW_AW-1:0]   row_r, row_nxt;
  logic [bffa_pkg::LANE_W-1:0]   lane_r, lane_nxt;
  logic [7:0]                    wbyte_r, wbyte_nxt;
  logic                          out_strobe_r, out_strobe_nxt;
  bffa_pkg::out_t                out_data_r, out_data_nxt;

  // Bitmap store
  logic [bffa_pkg::ROW_BITS-1:0] mem [bffa_pkg::ROWS];
  logic [bffa_pkg::ROWS-1:0]     vld_r;
  logic [bffa_pkg::ROW_BITS-1:0] rd_data_r;
  logic                          rd_vld_r;
  logic [bffa_pkg::ROW_AW-1:0]   rd_addr;
  logic                          wr_en;
  logic [bffa_pkg::ROW_AW-1:0]   wr_addr;
  logic [bffa_pkg::ROW_BITS-1:0] wr_data;

  // Row examination
  logic [bffa_pkg::ROW_BITS-1:0] eff_row;
  logic [bffa_pkg::ROW_BITS-1:0] scan_row;
  logic [bffa_pkg::ROW_BITS-1:0] merged_row;
  logic [bffa_pkg::IDX_W-1:0]    byte_idx;
  logic                          found;
  logic [bffa_pkg::POS_W-1:0]    pos;
  logic                          start_acc;

  assign start_acc = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // Treat a never-written row as all free
  assign eff_row = rd_vld_r ? rd_data_r : '0;

  // Mask bytes past the scanned range as full, then find the first clear bit
  always_comb begin
    scan_row = eff_row;
    byte_idx = '0;
    for (int j = 0; j < bffa_pkg::ROW_BYTES; j++) begin
      byte_idx = {1'b0, row_r, bffa_pkg::LANE_W'(j)};
      if (byte_idx >= bffa_pkg::IDX_W'(bffa_pkg::SCAN_BYTES)) begin
        scan_row[bffa_pkg::ROW_BITS-1-8*j -: 8] = 8'hFF;
      end
    end
    found = ~&scan_row;
    pos   = '0;
    // lowest sector sits at the top bit; last hit in this order wins
    for (int k = bffa_pkg::ROW_BITS - 1; k >= 0; k--) begin
      if (!scan_row[bffa_pkg::ROW_BITS-1-k]) begin
        pos = bffa_pkg::POS_W'(k);
      end
    end
  end

  // Replace one byte lane for a bitmap byte write
  always_comb begin
    merged_row = eff_row;
    for (int j = 0; j < bffa_pkg::ROW_BYTES; j++) begin
      if (lane_r == bffa_pkg::LANE_W'(j)) begin
        merged_row[bffa_pkg::ROW_BITS-1-8*j -: 8] = wbyte_r;
      end
    end
  end

  // Sequence reads, write-backs and results
  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    lane_nxt       = lane_r;
    wbyte_nxt      = wbyte_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    rd_addr        = row_r + bffa_pkg::ROW_AW'(1);
    wr_en          = 1'b0;
    wr_addr        = row_r;
    wr_data        = merged_row;

    case (state_r)
      ST_IDLE: begin
        if (start_acc) begin
          if (in_data.action == bffa_pkg::ACT_WRITE) begin
            rd_addr   = in_data.byte_addr[7:bffa_pkg::LANE_W];
            row_nxt   = in_data.byte_addr[7:bffa_pkg::LANE_W];
            lane_nxt  = in_data.byte_addr[bffa_pkg::LANE_W-1:0];
            wbyte_nxt = in_data.byte_value;
            state_nxt = ST_WRITE;
          end else begin
            rd_addr   = '0;
            row_nxt   = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_WRITE: begin
        wr_en          = 1'b1;
        wr_data        = merged_row;
        out_strobe_nxt = 1'b1;
        out_data_nxt   = '{sector: '0, ok: 1'b1};
        state_nxt      = ST_IDLE;
      end
      ST_SCAN: begin
        // check the row arriving now while the next one is read
        if (found) begin
          wr_en          = 1'b1;
          wr_data        = eff_row | ({1'b1, {(bffa_pkg::ROW_BITS-1){1'b0}}} >> pos);
          out_strobe_nxt = 1'b1;
          out_data_nxt   = '{sector: {row_r, pos}, ok: 1'b1};
          state_nxt      = ST_IDLE;
        end else if (row_r == bffa_pkg::ROW_AW'(bffa_pkg::LAST_ROW)) begin
          out_strobe_nxt = 1'b1;
          out_data_nxt   = '{sector: '0, ok: 1'b0};
          state_nxt      = ST_IDLE;
        end else begin
          row_nxt = row_r + bffa_pkg::ROW_AW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
      vld_r        <= '0;
      rd_vld_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      rd_vld_r     <= vld_r[rd_addr];
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
    row_r      <= row_nxt;
    lane_r     <= lane_nxt;
    wbyte_r    <= wbyte_nxt;
    out_data_r <= out_data_nxt;
  end

  // Bitmap RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule
`default_nettype wire
